### sv/graph_depth_first_walk_assert.svh
// ----------------------------------------------------------------------------
// graph_depth_first_walk assertion macros
// shared property forms for the depth-first walk block
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEPTH_FIRST_WALK_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_WALK_ASSERT_SVH

// same-cycle implication
`define GDFW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdfw same-cycle check failed");

// next-cycle implication
`define GDFW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdfw next-cycle check failed");

`endif

### sv/gdfw_pkg.sv
// ----------------------------------------------------------------------------
// gdfw_pkg
// types and codes shared by the depth-first walk block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdfw_pkg;

  localparam int VERTEX_W = 6;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_VISITED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EDGE_REJ  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_START_REJ = 2'd2;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_BRD,
    ST_EDGE_B,
    ST_START,
    ST_CUR,
    ST_NODE,
    ST_HEAD,
    ST_POP
  } state_t;

endpackage

### sv/gdfw_ram.sv
// ----------------------------------------------------------------------------
// gdfw_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdfw_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/graph_depth_first_walk.sv
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// undirected graph in adjacency lists with a depth-first walk engine
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is done. Results appear for one cycle with out_valid and must be
// taken then. An add-edge steps through EDGE_A, EDGE_BRD and EDGE_B; a clear
// or a rejected item is done in IDLE. A walk passes CUR and NODE per list
// node read, HEAD per vertex pushed, and CUR and POP per vertex popped; each
// step waits on the registered read of the node, list-head or stack ram. The
// last visited vertex is held back until the walk ends so that it carries
// last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_depth_first_walk
  import gdfw_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_NODES    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [VERTEX_W-1:0] in_vertex_a,
  input  logic [VERTEX_W-1:0] in_vertex_b,
  output logic                out_valid,
  output logic [VERTEX_W-1:0] out_visited_vertex,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

`include "graph_depth_first_walk_assert.svh"

  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
  localparam int NIDX_W  = $clog2(MAX_NODES);
  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int NWORD_W = VERTEX_W + NODE_W;

  localparam logic [NODE_W-1:0]  NODE_NIL  = NODE_W'(MAX_NODES);
  localparam logic [NODE_W:0]    NODE_LIM  = (NODE_W + 1)'(MAX_NODES);
  localparam logic [CFG_W-1:0]   VCNT_MAX  = CFG_W'(MAX_VERTICES);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(2);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]        vertex_count_r;
  logic [MAX_VERTICES-1:0] head_vld_r, head_vld_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [NODE_W-1:0]       nodes_used_r, nodes_used_nxt;
  logic [DEPTH_W-1:0]      depth_r, depth_nxt;
  logic [VERTEX_W-1:0]     a_r, a_nxt;
  logic [VERTEX_W-1:0]     b_r, b_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [VERTEX_W-1:0]     pend_r, pend_nxt;
  logic                    hd_vld_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [VERTEX_W-1:0]     out_vertex_r, out_vertex_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    head_we;
  logic [VIDX_W-1:0]       head_waddr, head_raddr;
  logic [NODE_W-1:0]       head_wdata, head_rdata, head_val;

  logic                    node_we;
  logic [NIDX_W-1:0]       node_waddr, node_raddr;
  logic [NWORD_W-1:0]      node_wdata, node_rdata;
  logic [VERTEX_W-1:0]     node_tgt;
  logic [NODE_W-1:0]       node_lnk;

  logic                    stk_we;
  logic [VIDX_W-1:0]       stk_waddr, stk_raddr;
  logic [NODE_W-1:0]       stk_wdata, stk_rdata;

  logic [CFG_W-1:0]        live_cnt;
  logic                    take;
  logic                    a_bad, b_bad, pool_full;

  gdfw_ram #(.DEPTH(MAX_VERTICES), .WIDTH(NODE_W)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  gdfw_ram #(.DEPTH(MAX_NODES), .WIDTH(NWORD_W)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  gdfw_ram #(.DEPTH(MAX_VERTICES), .WIDTH(NODE_W)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign live_cnt  = (vertex_count_r > VCNT_MAX) ? VCNT_MAX : vertex_count_r;
  assign take      = start && (state_r == ST_IDLE);
  assign a_bad     = {1'b0, in_vertex_a} >= live_cnt;
  assign b_bad     = {1'b0, in_vertex_b} >= live_cnt;
  assign pool_full = ({1'b0, nodes_used_r} + (NODE_W + 1)'(2)) > NODE_LIM;
  assign head_val  = hd_vld_r ? head_rdata : NODE_NIL;
  assign node_tgt  = node_rdata[NWORD_W-1:NODE_W];
  assign node_lnk  = node_rdata[NODE_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_kind == KIND_EDGE && !(a_bad || b_bad || pool_full)) begin
            state_nxt = ST_EDGE_A;
          end else if (in_kind == KIND_START && !a_bad) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_EDGE_A:   state_nxt = ST_EDGE_BRD;
      ST_EDGE_BRD: state_nxt = ST_EDGE_B;
      ST_EDGE_B:   state_nxt = ST_IDLE;
      ST_START:    state_nxt = ST_CUR;
      ST_CUR: begin
        if (cur_r != NODE_NIL) begin
          state_nxt = ST_NODE;
        end else if (depth_r == DEPTH_ONE) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_NODE: begin
        if (visited_r[node_tgt[VIDX_W-1:0]]) begin
          state_nxt = ST_CUR;
        end else begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD:     state_nxt = ST_CUR;
      ST_POP:      state_nxt = ST_CUR;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_vld_nxt   = head_vld_r;
    visited_nxt    = visited_r;
    nodes_used_nxt = nodes_used_r;
    depth_nxt      = depth_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_vertex_nxt = out_vertex_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    head_we        = 1'b0;
    head_waddr     = a_r[VIDX_W-1:0];
    head_wdata     = nodes_used_r;
    head_raddr     = a_r[VIDX_W-1:0];
    node_we        = 1'b0;
    node_waddr     = nodes_used_r[NIDX_W-1:0];
    node_wdata     = {b_r, head_val};
    node_raddr     = cur_r[NIDX_W-1:0];
    stk_we         = 1'b0;
    stk_waddr      = VIDX_W'(depth_r - DEPTH_ONE);
    stk_wdata      = node_lnk;
    stk_raddr      = VIDX_W'(depth_r - DEPTH_TWO);
    case (state_r)
      ST_IDLE: begin
        head_raddr = in_vertex_a[VIDX_W-1:0];
        if (take) begin
          a_nxt = in_vertex_a;
          b_nxt = in_vertex_b;
          case (in_kind)
            KIND_EDGE: begin
              if (a_bad || b_bad || pool_full) begin
                out_valid_nxt  = 1'b1;
                out_vertex_nxt = '0;
                out_status_nxt = STATUS_EDGE_REJ;
                out_last_nxt   = 1'b1;
              end
            end
            KIND_START: begin
              if (a_bad) begin
                out_valid_nxt  = 1'b1;
                out_vertex_nxt = '0;
                out_status_nxt = STATUS_START_REJ;
                out_last_nxt   = 1'b1;
              end else begin
                visited_nxt[in_vertex_a[VIDX_W-1:0]] = 1'b1;
                pend_nxt = in_vertex_a;
              end
            end
            KIND_CLEAR: begin
              head_vld_nxt   = '0;
              visited_nxt    = '0;
              nodes_used_nxt = '0;
              depth_nxt      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE_A: begin
        node_we                          = 1'b1;
        node_wdata                       = {b_r, head_val};
        head_we                          = 1'b1;
        head_waddr                       = a_r[VIDX_W-1:0];
        head_vld_nxt[a_r[VIDX_W-1:0]]    = 1'b1;
        nodes_used_nxt                   = nodes_used_r + NODE_W'(1);
      end
      ST_EDGE_BRD: begin
        head_raddr = b_r[VIDX_W-1:0];
      end
      ST_EDGE_B: begin
        node_we                          = 1'b1;
        node_wdata                       = {a_r, head_val};
        head_we                          = 1'b1;
        head_waddr                       = b_r[VIDX_W-1:0];
        head_vld_nxt[b_r[VIDX_W-1:0]]    = 1'b1;
        nodes_used_nxt                   = nodes_used_r + NODE_W'(1);
      end
      ST_START: begin
        cur_nxt   = head_val;
        depth_nxt = DEPTH_ONE;
      end
      ST_CUR: begin
        if (cur_r == NODE_NIL) begin
          if (depth_r == DEPTH_ONE) begin
            out_valid_nxt  = 1'b1;
            out_vertex_nxt = pend_r;
            out_status_nxt = STATUS_VISITED;
            out_last_nxt   = 1'b1;
            depth_nxt      = '0;
          end else begin
            depth_nxt = depth_r - DEPTH_ONE;
          end
        end
      end
      ST_NODE: begin
        cur_nxt    = node_lnk;
        head_raddr = node_tgt[VIDX_W-1:0];
        if (!visited_r[node_tgt[VIDX_W-1:0]]) begin
          visited_nxt[node_tgt[VIDX_W-1:0]] = 1'b1;
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = pend_r;
          out_status_nxt = STATUS_VISITED;
          out_last_nxt   = 1'b0;
          pend_nxt       = node_tgt;
          stk_we         = 1'b1;
          depth_nxt      = depth_r + DEPTH_ONE;
        end
      end
      ST_HEAD: begin
        cur_nxt = head_val;
      end
      ST_POP: begin
        cur_nxt = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      vertex_count_r <= VCOUNT_RESET;
      head_vld_r     <= '0;
      visited_r      <= '0;
      nodes_used_r   <= '0;
      depth_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_vld_r   <= head_vld_nxt;
      visited_r    <= visited_nxt;
      nodes_used_r <= nodes_used_nxt;
      depth_r      <= depth_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vertex_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    cur_r        <= cur_nxt;
    pend_r       <= pend_nxt;
    hd_vld_r     <= head_vld_r[head_raddr];
    out_vertex_r <= out_vertex_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_vertex_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

  `GDFW_ASSERT_NOW(a_cursor_in_pool,
    (state_r == ST_CUR) && (cur_r != NODE_NIL),
    cur_r < nodes_used_r)
  `GDFW_ASSERT_NOW(a_pool_bound, 1'b1, nodes_used_r <= NODE_W'(MAX_NODES))
  `GDFW_ASSERT_NEXT(a_clear_quiet,
    take && (in_kind == KIND_CLEAR),
    !busy && !out_valid && (nodes_used_r == '0))
  `GDFW_ASSERT_NOW(a_walk_depth,
    (state_r == ST_CUR) || (state_r == ST_NODE),
    (depth_r != '0) && (depth_r <= DEPTH_W'(MAX_VERTICES)))

endmodule
